// File: sv/pngse_pkg.sv
// shared types, constants and byte functions of the png stored-frame encoder
package pngse_pkg;

    localparam logic [1:0] CFG_FORMAT = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    localparam logic [1:0] FMT_XRGB8888 = 2'd1;
    localparam logic [1:0] FMT_RGB565   = 2'd2;

    localparam logic [9:0]  MAX_WIDTH        = 10'd512;
    localparam logic [8:0]  MAX_HEIGHT       = 9'd478;
    localparam logic [15:0] STORED_BLOCK_MAX = 16'hffff;
    localparam logic [31:0] CRC_POLY         = 32'hedb88320;
    localparam logic [16:0] ADLER_MOD        = 17'd65521;

    // byte positions inside the header, block header and trailer sequences
    localparam logic [5:0] HDR_LAST  = 6'd42;
    localparam logic [5:0] HDR_CLOSE = 6'd32;
    localparam logic [5:0] BLK_LAST  = 6'd4;
    localparam logic [5:0] TRL_CLOSE = 6'd7;
    localparam logic [5:0] TRL_LAST  = 6'd19;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CALC,
        S_HDR,
        S_RAW,
        S_BLK,
        S_TRL
    } t_state;

    typedef struct packed {
        logic       crc_en;
        logic       crc_close;
        logic       adl_en;
        logic       adl_init;
        logic [7:0] data;
    } t_ck_ctrl;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

    // c * 255 / 31 with floor
    function automatic logic [7:0] exp5(input logic [4:0] c);
        return {c, 3'b000} + 8'(c >= 5'd5) + 8'(c >= 5'd9) + 8'(c >= 5'd14)
             + 8'(c >= 5'd18) + 8'(c >= 5'd23) + 8'(c >= 5'd27) + 8'(c == 5'd31);
    endfunction

    // c * 255 / 63 with floor
    function automatic logic [7:0] exp6(input logic [5:0] c);
        return {c, 2'b00} + 8'(c >= 6'd21) + 8'(c >= 6'd42) + 8'(c == 6'd63);
    endfunction

endpackage

// File: sv/pngse_cksum.sv
// running chunk crc-32 and zlib adler-32 registers
module pngse_cksum import pngse_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ck_ctrl    i_ctrl,
    output logic [31:0] o_crc,
    output logic [15:0] o_adler_lo,
    output logic [15:0] o_adler_hi
);
    logic [31:0] r_crc, n_crc;
    logic [15:0] r_lo, n_lo, r_hi, n_hi;
    logic [16:0] w_lo_sum, w_hi_sum;

    always_comb begin
        w_lo_sum = 17'(r_lo) + 17'(i_ctrl.data);
        n_lo     = (w_lo_sum >= ADLER_MOD) ? 16'(w_lo_sum - ADLER_MOD) : w_lo_sum[15:0];
        w_hi_sum = 17'(r_hi) + 17'(n_lo);
        n_hi     = (w_hi_sum >= ADLER_MOD) ? 16'(w_hi_sum - ADLER_MOD) : w_hi_sum[15:0];
        n_crc    = crc_byte(r_crc, i_ctrl.data);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= '1;
            r_lo  <= 16'd1;
            r_hi  <= 16'd0;
        end else begin
            if (i_ctrl.crc_close) begin
                r_crc <= '1;
            end else if (i_ctrl.crc_en) begin
                r_crc <= n_crc;
            end
            if (i_ctrl.adl_init) begin
                r_lo <= 16'd1;
                r_hi <= 16'd0;
            end else if (i_ctrl.adl_en) begin
                r_lo <= n_lo;
                r_hi <= n_hi;
            end
        end
    end

    assign o_crc      = r_crc;
    assign o_adler_lo = r_lo;
    assign o_adler_hi = r_hi;
endmodule

// File: sv/png_stored_frame_encoder.sv
// top level: png file builder, stored deflate blocks, one byte per cycle unless output stalls
//
//  channel  direction  handshake                 payload
//  in       sink       i_in_valid / o_in_ready   i_pixel_word
//  out      source     o_out_valid / i_out_ready o_out_byte, o_run_last, o_file_end
//  cfg      sink       i_cfg_we                  i_cfg_idx, i_cfg_data
//
// an item of a running frame is accepted in the idle state and then sends its raw bytes (a
// filter byte at a row start, then r, g and b), plus 5 stored block header bytes where one begins.
// the first item of a frame adds a length calculation (a multiply state, then one subtraction
// step per stored block) and 43 header bytes; the last item adds the 20 trailer bytes.
// reset is synchronous, active low; no clearing pass is needed.
// a stalled output holds the sequencer; the input is taken only in the idle state.
module png_stored_frame_encoder import pngse_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_pixel_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_run_last,
    output logic        o_file_end,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [9:0]  i_cfg_data
);
    // configuration and latched frame geometry
    logic [1:0]  r_cfg_fmt, r_lat_fmt;
    logic [9:0]  r_cfg_w, r_lat_w;
    logic [8:0]  r_cfg_h, r_lat_h;

    // sequencer state
    t_state      r_state, n_state;
    logic [5:0]  r_idx;
    logic [1:0]  r_k;
    logic        r_started, r_in_frame, r_pend;
    logic [31:0] r_pix;
    logic [9:0]  r_col;
    logic [8:0]  r_row;
    logic [15:0] r_blk_rem;
    logic [19:0] r_raw_rem, r_tmp;
    logic [3:0]  r_blocks;

    // output register
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_run_last, r_file_end;

    // combinational
    logic        w_acc, w_slot, w_emit, w_last, w_end, w_eof;
    logic [7:0]  w_byte, w_r, w_g, w_b, w_raw_byte;
    logic [15:0] w_len;
    logic        w_final;
    logic [10:0] w_row_bytes;
    logic [31:0] w_zlen, w_crc_inv;
    logic [31:0] w_crc;
    logic [15:0] w_adl_lo, w_adl_hi;
    logic [31:0] w_adler;
    t_ck_ctrl    w_ck;

    assign w_acc      = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign w_slot     = !r_out_valid || i_out_ready;

    // pixel expansion to 8-bit rgb
    always_comb begin
        case (r_lat_fmt)
            FMT_XRGB8888: begin
                w_r = r_pix[23:16];
                w_g = r_pix[15:8];
                w_b = r_pix[7:0];
            end
            FMT_RGB565: begin
                w_r = exp5(r_pix[15:11]);
                w_g = exp6(r_pix[10:5]);
                w_b = exp5(r_pix[4:0]);
            end
            default: begin
                w_r = exp5(r_pix[14:10]);
                w_g = exp5(r_pix[9:5]);
                w_b = exp5(r_pix[4:0]);
            end
        endcase
        case (r_k)
            2'd0:    w_raw_byte = 8'd0;
            2'd1:    w_raw_byte = w_r;
            2'd2:    w_raw_byte = w_g;
            default: w_raw_byte = w_b;
        endcase
    end

    // stored block length and frame-level sizes
    assign w_final     = (r_raw_rem <= 20'(STORED_BLOCK_MAX));
    assign w_len       = w_final ? r_raw_rem[15:0] : STORED_BLOCK_MAX;
    assign w_row_bytes = 11'({r_lat_w, 1'b0}) + 11'(r_lat_w) + 11'd1;
    assign w_zlen      = 32'(r_raw_rem) + 32'({r_blocks, 2'b00}) + 32'(r_blocks) + 32'd6;
    assign w_crc_inv   = ~w_crc;
    assign w_adler     = {w_adl_hi, w_adl_lo};
    assign w_eof       = (r_col == r_lat_w - 10'd1) && (r_row == r_lat_h - 9'd1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (r_pend)           n_state = S_TRL;
                    else if (!r_in_frame) n_state = S_MUL;
                    else                  n_state = S_RAW;
                end
            end
            S_MUL:  n_state = S_CALC;
            S_CALC: if (r_tmp == 20'd0) n_state = S_HDR;
            S_HDR:  if (w_emit && r_idx == HDR_LAST) n_state = S_RAW;
            S_RAW: begin
                if (r_blk_rem == 16'd0) begin
                    n_state = S_BLK;
                end else if (w_emit && r_k == 2'd3) begin
                    n_state = (w_eof && !r_started) ? S_TRL : S_IDLE;
                end
            end
            S_BLK:  if (w_emit && r_idx == BLK_LAST) n_state = S_RAW;
            S_TRL:  if (w_emit && r_idx == TRL_LAST) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // byte selection and checksum control
    always_comb begin
        w_emit = 1'b0;
        w_byte = 8'd0;
        w_last = 1'b0;
        w_end  = 1'b0;
        w_ck   = '0;
        case (r_state)
            S_MUL: w_ck.adl_init = 1'b1;
            S_HDR: begin
                w_emit = w_slot;
                case (r_idx)
                    6'd0:  w_byte = 8'd137;
                    6'd1:  w_byte = 8'd80;
                    6'd2:  w_byte = 8'd78;
                    6'd3:  w_byte = 8'd71;
                    6'd4:  w_byte = 8'd13;
                    6'd5:  w_byte = 8'd10;
                    6'd6:  w_byte = 8'd26;
                    6'd7:  w_byte = 8'd10;
                    6'd11: w_byte = 8'd13;
                    6'd12: w_byte = 8'd73;
                    6'd13: w_byte = 8'd72;
                    6'd14: w_byte = 8'd68;
                    6'd15: w_byte = 8'd82;
                    6'd18: w_byte = 8'({r_lat_w[9:8]});
                    6'd19: w_byte = r_lat_w[7:0];
                    6'd22: w_byte = 8'({r_lat_h[8]});
                    6'd23: w_byte = r_lat_h[7:0];
                    6'd24: w_byte = 8'd8;
                    6'd25: w_byte = 8'd2;
                    6'd29: w_byte = w_crc_inv[31:24];
                    6'd30: w_byte = w_crc_inv[23:16];
                    6'd31: w_byte = w_crc_inv[15:8];
                    6'd32: w_byte = w_crc_inv[7:0];
                    6'd33: w_byte = w_zlen[31:24];
                    6'd34: w_byte = w_zlen[23:16];
                    6'd35: w_byte = w_zlen[15:8];
                    6'd36: w_byte = w_zlen[7:0];
                    6'd37: w_byte = 8'd73;
                    6'd38: w_byte = 8'd68;
                    6'd39: w_byte = 8'd65;
                    6'd40: w_byte = 8'd84;
                    6'd41: w_byte = 8'h78;
                    6'd42: w_byte = 8'h01;
                    default: w_byte = 8'd0;
                endcase
                w_ck.crc_en    = w_emit && (r_idx inside {[6'd12:6'd28], [6'd37:6'd42]});
                w_ck.crc_close = w_emit && (r_idx == HDR_CLOSE);
            end
            S_RAW: begin
                w_emit        = w_slot && (r_blk_rem != 16'd0);
                w_byte        = w_raw_byte;
                w_last        = (r_k == 2'd3) && (!w_eof || r_started);
                w_ck.crc_en   = w_emit;
                w_ck.adl_en   = w_emit;
            end
            S_BLK: begin
                w_emit = w_slot;
                case (r_idx)
                    6'd0:    w_byte = 8'(w_final);
                    6'd1:    w_byte = w_len[7:0];
                    6'd2:    w_byte = w_len[15:8];
                    6'd3:    w_byte = ~w_len[7:0];
                    default: w_byte = ~w_len[15:8];
                endcase
                w_ck.crc_en = w_emit;
            end
            S_TRL: begin
                w_emit = w_slot;
                case (r_idx)
                    6'd0:  w_byte = w_adler[31:24];
                    6'd1:  w_byte = w_adler[23:16];
                    6'd2:  w_byte = w_adler[15:8];
                    6'd3:  w_byte = w_adler[7:0];
                    6'd4:  w_byte = w_crc_inv[31:24];
                    6'd5:  w_byte = w_crc_inv[23:16];
                    6'd6:  w_byte = w_crc_inv[15:8];
                    6'd7:  w_byte = w_crc_inv[7:0];
                    6'd12: w_byte = 8'd73;
                    6'd13: w_byte = 8'd69;
                    6'd14: w_byte = 8'd78;
                    6'd15: w_byte = 8'd68;
                    6'd16: w_byte = w_crc_inv[31:24];
                    6'd17: w_byte = w_crc_inv[23:16];
                    6'd18: w_byte = w_crc_inv[15:8];
                    6'd19: w_byte = w_crc_inv[7:0];
                    default: w_byte = 8'd0;
                endcase
                w_last         = (r_idx == TRL_LAST);
                w_end          = (r_idx == TRL_LAST);
                w_ck.crc_en    = w_emit && (r_idx inside {[6'd0:6'd3], [6'd12:6'd15]});
                w_ck.crc_close = w_emit && (r_idx == TRL_CLOSE || r_idx == TRL_LAST);
            end
            default: w_emit = 1'b0;
        endcase
        w_ck.data = w_byte;
    end

    pngse_cksum u_cksum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_ck),
        .o_crc      (w_crc),
        .o_adler_lo (w_adl_lo),
        .o_adler_hi (w_adl_hi)
    );

    // control and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_fmt   <= 2'd0;
            r_cfg_w     <= 10'd256;
            r_cfg_h     <= 9'd224;
            r_lat_fmt   <= 2'd0;
            r_lat_w     <= 10'd256;
            r_lat_h     <= 9'd224;
            r_idx       <= 6'd0;
            r_k         <= 2'd0;
            r_started   <= 1'b0;
            r_in_frame  <= 1'b0;
            r_pend      <= 1'b0;
            r_col       <= 10'd0;
            r_row       <= 9'd0;
            r_blk_rem   <= 16'd0;
            r_raw_rem   <= 20'd0;
            r_tmp       <= 20'd0;
            r_blocks    <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FORMAT: r_cfg_fmt <= i_cfg_data[1:0];
                    CFG_WIDTH:  r_cfg_w   <= i_cfg_data;
                    CFG_HEIGHT: r_cfg_h   <= i_cfg_data[8:0];
                    default:    ;
                endcase
            end

            // item intake; the geometry latches only at a frame start
            if (w_acc) begin
                r_pix     <= i_pixel_word;
                r_started <= !r_pend && !r_in_frame;
                r_k       <= (r_col == 10'd0) ? 2'd0 : 2'd1;
                if (!r_pend && !r_in_frame) begin
                    r_lat_fmt <= r_cfg_fmt;
                    r_lat_w   <= (r_cfg_w == 10'd0) ? 10'd1 :
                                 (r_cfg_w > MAX_WIDTH) ? MAX_WIDTH : r_cfg_w;
                    r_lat_h   <= (r_cfg_h == 9'd0) ? 9'd1 :
                                 (r_cfg_h > MAX_HEIGHT) ? MAX_HEIGHT : r_cfg_h;
                end
            end

            // raw size, then block count by repeated subtraction
            if (r_state == S_MUL) begin
                r_raw_rem <= 20'(w_row_bytes) * 20'(r_lat_h);
                r_tmp     <= 20'(w_row_bytes) * 20'(r_lat_h);
                r_blocks  <= 4'd0;
            end
            if (r_state == S_CALC && r_tmp != 20'd0) begin
                r_tmp    <= (r_tmp > 20'(STORED_BLOCK_MAX)) ?
                            r_tmp - 20'(STORED_BLOCK_MAX) : 20'd0;
                r_blocks <= r_blocks + 4'd1;
            end

            // byte index within header, block header and trailer
            if (w_emit && (r_state == S_HDR || r_state == S_BLK || r_state == S_TRL)) begin
                r_idx <= (n_state != r_state) ? 6'd0 : r_idx + 6'd1;
            end

            if (w_emit && r_state == S_HDR && r_idx == HDR_LAST) begin
                r_col      <= 10'd0;
                r_row      <= 9'd0;
                r_blk_rem  <= 16'd0;
                r_in_frame <= 1'b1;
                r_k        <= 2'd0;
            end

            if (w_emit && r_state == S_BLK && r_idx == BLK_LAST) begin
                r_blk_rem <= w_len;
            end

            if (w_emit && r_state == S_RAW) begin
                r_blk_rem <= r_blk_rem - 16'd1;
                r_raw_rem <= r_raw_rem - 20'd1;
                r_k       <= r_k + 2'd1;
                if (r_k == 2'd3) begin
                    if (r_col == r_lat_w - 10'd1) begin
                        r_col <= 10'd0;
                        if (r_row == r_lat_h - 9'd1) begin
                            r_row <= 9'd0;
                            if (r_started) r_pend <= 1'b1;
                        end else begin
                            r_row <= r_row + 9'd1;
                        end
                    end else begin
                        r_col <= r_col + 10'd1;
                    end
                end
            end

            if (w_emit && r_state == S_TRL && r_idx == TRL_LAST) begin
                r_in_frame <= 1'b0;
                r_pend     <= 1'b0;
            end

            if (w_slot) begin
                r_out_valid <= w_emit;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_byte <= w_byte;
            r_run_last <= w_last;
            r_file_end <= w_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_run_last  = r_run_last;
    assign o_file_end  = r_file_end;

    // the file's final byte always closes the item that caused it
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_file_end) |-> o_run_last)
        else $error("file end without run last");

    // a raw byte is only sent while frame bytes remain
    a_raw_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RAW && r_blk_rem != 16'd0) |-> (r_raw_rem != 20'd0))
        else $error("raw byte beyond frame size");

    // a pending trailer belongs to an open frame
    a_pend_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_in_frame)
        else $error("trailer pending outside a frame");

    // column counter stays inside the latched width
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_frame |-> (r_col < r_lat_w))
        else $error("column beyond width");
endmodule
